// ===== rtl/pls_pkg.sv =====
`default_nettype none

package pls_pkg;

  localparam int unsigned DefCapacity = 16;
  localparam int unsigned OpW         = 3;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned PosW        = 6;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned LenW        = 5;

  typedef enum logic [OpW-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_END   = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FIRST = 3'd3,
    OP_DEL_END   = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_READ_AT   = 3'd6
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;  // capture the request payload
    logic exec;  // run the operation and update the result register
  } ctl_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/pls_intf.sv =====
`default_nettype none

interface pls_req_if;
  logic                              valid;
  logic                              ready;
  logic [pls_pkg::OpW-1:0]           opcode;
  logic signed [pls_pkg::ValueW-1:0] value;
  logic [pls_pkg::PosW-1:0]          position;

  modport source (output valid, output opcode, output value, output position, input ready);
  modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface

interface pls_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [pls_pkg::StatusW-1:0]       status;
  logic [pls_pkg::LenW-1:0]          length;
  logic signed [pls_pkg::ValueW-1:0] read_value;

  modport source (output valid, output status, output length, output read_value, input ready);
  modport sink   (input valid, input status, input length, input read_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/pls_ctrl.sv =====
`default_nettype none

module pls_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  output logic                   req_ready_o,
  output logic                   rsp_valid_o,
  input  wire logic              rsp_ready_i,
  output pls_pkg::ctl_cmd_t      cmd_o
);

  pls_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pls_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    // drop the result once it has been taken
    out_valid_d = out_valid_q && !rsp_ready_i;
    unique case (state_q)
      pls_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = pls_pkg::S_EXEC;
        end
      end
      pls_pkg::S_EXEC: begin
        // hold until the result register is free
        if (!out_valid_q || rsp_ready_i) begin
          cmd_o.exec  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = pls_pkg::S_IDLE;
        end
      end
      default: state_d = pls_pkg::S_IDLE;
    endcase
  end

  assign rsp_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/pls_dpath.sv =====
`default_nettype none

module pls_dpath #(
  parameter int unsigned CAPACITY = pls_pkg::DefCapacity
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire pls_pkg::ctl_cmd_t                 cmd_i,
  input  wire logic [pls_pkg::OpW-1:0]           opcode_i,
  input  wire logic signed [pls_pkg::ValueW-1:0] value_i,
  input  wire logic [pls_pkg::PosW-1:0]          position_i,
  output logic [pls_pkg::StatusW-1:0]            status_o,
  output logic [pls_pkg::LenW-1:0]               length_o,
  output logic signed [pls_pkg::ValueW-1:0]      read_value_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CmpW = ((CntW > pls_pkg::PosW) ? CntW : pls_pkg::PosW) + 1;

  pls_pkg::op_e                      op_q;
  logic [pls_pkg::ValueW-1:0]        word_q;
  logic [pls_pkg::PosW-1:0]          pos_q;
  logic [CntW-1:0]                   count_q, count_d;
  logic [pls_pkg::ValueW-1:0]        cells_q [CAPACITY];
  logic [pls_pkg::ValueW-1:0]        cells_d [CAPACITY];
  pls_pkg::status_e                  res_status_q, status_d;
  logic [pls_pkg::LenW-1:0]          res_len_q;
  logic [pls_pkg::ValueW-1:0]        res_rd_q, rd_d;

  logic [CmpW-1:0] cnt_ext, pos_ext, idx;
  logic            do_ins, do_del, do_read;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= pls_pkg::op_e'(opcode_i);
      word_q <= value_i;
      pos_q  <= position_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_status_q <= status_d;
      res_len_q    <= pls_pkg::LenW'(count_d);
      res_rd_q     <= rd_d;
    end
  end

  // Decode the operation: target index, status and which update to apply.
  always_comb begin
    cnt_ext  = CmpW'(count_q);
    pos_ext  = CmpW'(pos_q);
    idx      = '0;
    status_d = pls_pkg::ST_OK;
    do_ins   = 1'b0;
    do_del   = 1'b0;
    do_read  = 1'b0;
    unique case (op_q)
      pls_pkg::OP_INS_FRONT, pls_pkg::OP_INS_END, pls_pkg::OP_INS_AT: begin
        if (op_q == pls_pkg::OP_INS_END) begin
          idx = cnt_ext;
        end else if (op_q == pls_pkg::OP_INS_AT) begin
          idx = pos_ext - CmpW'(1);
        end
        // position check comes before the full check
        if (op_q == pls_pkg::OP_INS_AT && (pos_ext == '0 || pos_ext > cnt_ext + CmpW'(1))) begin
          status_d = pls_pkg::ST_BADPOS;
        end else if (count_q == CntW'(CAPACITY)) begin
          status_d = pls_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      pls_pkg::OP_DEL_FIRST, pls_pkg::OP_DEL_END, pls_pkg::OP_DEL_AT,
      pls_pkg::OP_READ_AT: begin
        if (op_q == pls_pkg::OP_DEL_END) begin
          idx = cnt_ext - CmpW'(1);
        end else if (op_q == pls_pkg::OP_DEL_AT || op_q == pls_pkg::OP_READ_AT) begin
          idx = pos_ext - CmpW'(1);
        end
        if (count_q == '0) begin
          status_d = pls_pkg::ST_EMPTY;
        end else if ((op_q == pls_pkg::OP_DEL_AT || op_q == pls_pkg::OP_READ_AT) &&
                     (pos_ext == '0 || pos_ext > cnt_ext)) begin
          status_d = pls_pkg::ST_BADPOS;
        end else if (op_q == pls_pkg::OP_READ_AT) begin
          do_read = 1'b1;
        end else begin
          do_del = 1'b1;
        end
      end
      default: status_d = pls_pkg::ST_BADPOS;
    endcase
  end

  assign rd_d = do_read ? cells_q[idx[IdxW-1:0]] : '0;

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CntW'(1);
    end else if (do_del) begin
      count_d = count_q - CntW'(1);
    end
  end

  // Each cell either holds, takes the new word, or shifts from a neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [CmpW-1:0] pos_i;
    assign pos_i = CmpW'(i);

    if (i == 0) begin : g_first
      always_comb begin
        cells_d[i] = cells_q[i];
        if (do_ins && pos_i == idx) begin
          cells_d[i] = word_q;
        end else if (do_del && pos_i >= idx && pos_i + CmpW'(1) < cnt_ext) begin
          cells_d[i] = cells_q[i+1];
        end
      end
    end else if (i == CAPACITY - 1) begin : g_last
      always_comb begin
        cells_d[i] = cells_q[i];
        if (do_ins && pos_i == idx) begin
          cells_d[i] = word_q;
        end else if (do_ins && pos_i > idx && pos_i <= cnt_ext) begin
          cells_d[i] = cells_q[i-1];
        end
      end
    end else begin : g_mid
      always_comb begin
        cells_d[i] = cells_q[i];
        if (do_ins && pos_i == idx) begin
          cells_d[i] = word_q;
        end else if (do_ins && pos_i > idx && pos_i <= cnt_ext) begin
          cells_d[i] = cells_q[i-1];
        end else if (do_del && pos_i >= idx && pos_i + CmpW'(1) < cnt_ext) begin
          cells_d[i] = cells_q[i+1];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.exec) begin
        cells_q[i] <= cells_d[i];
      end
    end
  end

  assign status_o     = res_status_q;
  assign length_o     = res_len_q;
  assign read_value_o = res_rd_q;

endmodule

`default_nettype wire

// ===== rtl/positional_list_store.sv =====
// Bounded ordered list of signed 32-bit words, held as a row of CAPACITY
// register cells with the front of the list in cell 0. Each request
// transfer carries an opcode (insert front/end/at position, delete
// first/end/at position, read at position), a word and a 1-based position,
// and yields exactly one response transfer with a status (ok, empty,
// invalid position, full), the length after the operation and, for a
// successful read, the word read (zero otherwise). Each item is captured,
// then executed with all cells shifting in parallel against the decoded
// index; execution waits while the previous result is still unaccepted.
// The next request is taken as soon as the result is written, even while
// that result still waits on the response side. Failed operations change
// nothing. The length field carries the low five bits of the count.
`default_nettype none

module positional_list_store #(
  parameter int unsigned CAPACITY = pls_pkg::DefCapacity
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pls_req_if.sink    req_i,
  pls_rsp_if.source  rsp_o
);

  pls_pkg::ctl_cmd_t cmd;

  // Handshake sequencing: capture, execute, present the result.
  pls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  // Cell row, count and result register.
  pls_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .opcode_i     (req_i.opcode),
    .value_i      (req_i.value),
    .position_i   (req_i.position),
    .status_o     (rsp_o.status),
    .length_o     (rsp_o.length),
    .read_value_o (rsp_o.read_value)
  );

endmodule

`default_nettype wire

// ===== rtl/pls_checker.sv =====
`default_nettype none

module pls_checker #(
  parameter int unsigned CAPACITY = pls_pkg::DefCapacity
) (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              rsp_valid_i,
  input wire logic                              rsp_ready_i,
  input wire logic [pls_pkg::StatusW-1:0]       rsp_status_i,
  input wire logic [pls_pkg::LenW-1:0]          rsp_length_i,
  input wire logic signed [pls_pkg::ValueW-1:0] rsp_read_value_i
);

  // A stalled result holds.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i) &&
      $stable(rsp_length_i) && $stable(rsp_read_value_i))
    else $error("response changed while stalled");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (CAPACITY > 31) || (32'(rsp_length_i) <= CAPACITY))
    else $error("length beyond capacity");

  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == pls_pkg::ST_FULL |->
      rsp_length_i == pls_pkg::LenW'(CAPACITY))
    else $error("full reported below capacity");

  a_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == pls_pkg::ST_EMPTY |-> rsp_length_i == '0)
    else $error("empty reported with entries present");

  a_rd_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_read_value_i != '0 |-> rsp_status_i == pls_pkg::ST_OK)
    else $error("read data on a failed operation");

endmodule

bind positional_list_store pls_checker #(
  .CAPACITY (CAPACITY)
) u_pls_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_status_i     (rsp_o.status),
  .rsp_length_i     (rsp_o.length),
  .rsp_read_value_i (rsp_o.read_value)
);

`default_nettype wire

// ===== tb/tb_positional_list_store.sv =====
// Testbench for positional_list_store.
module tb_positional_list_store;
  import pls_pkg::*;

  localparam int unsigned Capacity      = DefCapacity;
  // Hold-off after the last response, and the no-transfer limit of the watchdog.
  localparam int unsigned DrainCycles   = 10;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned ReportLimit   = 10;
  // The opcode the package leaves unnamed; the block must answer it with bad position.
  localparam logic [OpW-1:0] OpUnused   = 3'd7;

  // One response as the block should produce it.
  typedef struct packed {
    status_e                    status;
    logic [LenW-1:0]            length;
    logic signed [ValueW-1:0]   read_value;
  } list_result_t;

  logic clk;
  logic rst_n;

  pls_req_if req_if ();
  pls_rsp_if rsp_if ();

  positional_list_store #(
    .CAPACITY (Capacity)
  ) u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Shadow copy of the list: word 0 is the front.
  logic signed [ValueW-1:0] list_words [Capacity];
  int                       list_len;

  // Responses still owed by the block, oldest first.
  list_result_t expected_results [$];

  // Set during the stretch where neither side idles.
  bit steady_flow;

  int mismatches;
  int requests_sent;
  int responses_checked;
  int status_hits [4];

  // Apply one operation to the shadow list and return the response it must give.
  function automatic list_result_t apply_list_op(logic [OpW-1:0] op,
                                                 logic signed [ValueW-1:0] word,
                                                 logic [PosW-1:0] pos);
    list_result_t res;
    int slot;
    int p;
    int i;
    res.status     = ST_OK;
    res.read_value = '0;
    p              = int'(pos);
    slot           = 0;
    case (op)
      OP_INS_FRONT, OP_INS_END, OP_INS_AT: begin
        if (op == OP_INS_END) slot = list_len;
        else if (op == OP_INS_AT) slot = p - 1;
        // Position is checked before capacity.
        if (op == OP_INS_AT && (p < 1 || p > list_len + 1)) begin
          res.status = ST_BADPOS;
        end else if (list_len >= Capacity) begin
          res.status = ST_FULL;
        end else begin
          for (i = list_len; i > slot; i--) list_words[i] = list_words[i-1];
          list_words[slot] = word;
          list_len++;
        end
      end
      OP_DEL_FIRST, OP_DEL_END, OP_DEL_AT, OP_READ_AT: begin
        if (op == OP_DEL_END) slot = list_len - 1;
        else if (op == OP_DEL_AT || op == OP_READ_AT) slot = p - 1;
        // Empty wins over a bad position.
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else if ((op == OP_DEL_AT || op == OP_READ_AT) && (p < 1 || p > list_len)) begin
          res.status = ST_BADPOS;
        end else if (op == OP_READ_AT) begin
          res.read_value = list_words[slot];
        end else begin
          for (i = slot; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      default: begin
        res.status = ST_BADPOS;
      end
    endcase
    res.length = LenW'(list_len);
    return res;
  endfunction

  // Mostly random words, with the extremes mixed in.
  function automatic logic signed [ValueW-1:0] pick_word();
    case ($urandom_range(19))
      0:       return {1'b1, {(ValueW-1){1'b0}}};
      1:       return {1'b0, {(ValueW-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly a legal position out of span choices, else zero, one past the end,
  // or anything the field can carry.
  function automatic logic [PosW-1:0] pick_pos(int span);
    int roll;
    roll = $urandom_range(99);
    if (span > 0 && roll < 80) return PosW'($urandom_range(span, 1));
    if (roll < 87) return '0;
    if (roll < 94) return PosW'(span + 1);
    return PosW'($urandom_range((1 << PosW) - 1));
  endfunction

  // Present one request, hold it until the block takes it, then log what it owes.
  // Valid only drops when a gap is inserted, so back-to-back transfers keep it high.
  task automatic send_item(logic [OpW-1:0] op, logic signed [ValueW-1:0] word,
                           logic [PosW-1:0] pos);
    list_result_t res;
    if (!steady_flow && $urandom_range(99) < 30) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.opcode   <= op;
    req_if.value    <= word;
    req_if.position <= pos;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    res = apply_list_op(op, word, pos);
    expected_results.push_back(res);
    status_hits[res.status]++;
    requests_sent++;
  endtask

  // Every removal and read on an empty list, plus bad positions and the unused opcode.
  task automatic test_empty_list();
    send_item(OP_DEL_FIRST, pick_word(), 6'd1);
    send_item(OP_DEL_END,   pick_word(), 6'd1);
    send_item(OP_DEL_AT,    pick_word(), 6'd1);
    send_item(OP_READ_AT,   pick_word(), 6'd1);
    send_item(OP_DEL_AT,    pick_word(), 6'd0);
    send_item(OP_INS_AT,    pick_word(), 6'd0);
    send_item(OP_INS_AT,    pick_word(), 6'd2);
    send_item(OpUnused,     pick_word(), 6'd1);
  endtask

  // Each operation at least once with extreme words; end on an empty list again.
  task automatic test_basic_ops();
    send_item(OP_INS_FRONT, {1'b1, {(ValueW-1){1'b0}}}, 6'd0);
    send_item(OP_INS_END,   {1'b0, {(ValueW-1){1'b1}}}, 6'd63);
    send_item(OP_INS_AT,    '0, 6'd2);
    send_item(OP_INS_AT,    '1, 6'd4);
    send_item(OP_INS_AT,    pick_word(), 6'd63);
    send_item(OP_READ_AT,   pick_word(), 6'd1);
    send_item(OP_READ_AT,   pick_word(), 6'd4);
    send_item(OP_READ_AT,   pick_word(), 6'd5);
    send_item(OP_READ_AT,   pick_word(), 6'd63);
    send_item(OP_DEL_AT,    pick_word(), 6'd2);
    send_item(OP_DEL_FIRST, pick_word(), 6'd0);
    send_item(OP_DEL_END,   pick_word(), 6'd0);
    send_item(OP_DEL_AT,    pick_word(), 6'd1);
  endtask

  // Fill to capacity, knock on the full list, then drain with reads mixed in.
  task automatic test_fill_and_drain(int rounds);
    logic [OpW-1:0] op;
    repeat (rounds) begin
      while (list_len < Capacity) begin
        op = OpW'($urandom_range(OP_INS_AT, OP_INS_FRONT));
        send_item(op, pick_word(), pick_pos(list_len + 1));
      end
      // One past the end is a legal position, so it must report full;
      // two past must report bad position.
      send_item(OP_INS_FRONT, pick_word(), pick_pos(list_len + 1));
      send_item(OP_INS_AT,    pick_word(), PosW'(list_len + 1));
      send_item(OP_INS_AT,    pick_word(), PosW'(list_len + 2));
      send_item(OP_READ_AT,   pick_word(), PosW'(list_len));
      while (list_len > 0) begin
        if ($urandom_range(3) == 0) op = OP_READ_AT;
        else op = OpW'($urandom_range(OP_DEL_AT, OP_DEL_FIRST));
        send_item(op, pick_word(), pick_pos(list_len));
      end
      repeat (2) send_item(OpW'($urandom_range(OP_READ_AT, OP_DEL_FIRST)), pick_word(),
                           pick_pos(1));
    end
  endtask

  // Free mix of operations; the length wanders, with a stretch free of idling.
  task automatic test_random_mix(int count);
    logic [OpW-1:0] op;
    int span;
    for (int n = 0; n < count; n++) begin
      if (n == count / 3) steady_flow = 1'b1;
      if (n == count / 3 + 120) steady_flow = 1'b0;
      if ($urandom_range(99) < 2) op = OpUnused;
      else op = OpW'($urandom_range(OP_READ_AT, OP_INS_FRONT));
      span = (op <= OP_INS_AT) ? list_len + 1 : list_len;
      send_item(op, pick_word(), pick_pos(span));
    end
    steady_flow = 1'b0;
  endtask

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= ReportLimit) $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  // Response side: stall about 30% of cycles unless in the steady stretch.
  always @(posedge clk) begin
    rsp_if.ready <= steady_flow || ($urandom_range(99) >= 30);
  end

  // Compare each response transfer against the oldest owed result.
  always @(posedge clk) begin
    list_result_t exp_res;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      responses_checked++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected response status=%0d length=%0d read_value=%0d",
                                  rsp_if.status, rsp_if.length, rsp_if.read_value));
      end else begin
        exp_res = expected_results.pop_front();
        if (rsp_if.status !== exp_res.status || rsp_if.length !== exp_res.length ||
            rsp_if.read_value !== exp_res.read_value) begin
          report_mismatch($sformatf({"expected status=%0d length=%0d read_value=%0d, ",
                                     "got status=%0d length=%0d read_value=%0d"},
                                    exp_res.status, exp_res.length, exp_res.read_value,
                                    rsp_if.status, rsp_if.length, rsp_if.read_value));
        end
      end
    end
  end

  // Stop the run if no transfer happens on either side for too long.
  initial begin
    int stuck;
    stuck = 0;
    @(posedge rst_n);
    while (stuck < WatchdogLimit) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) stuck = 0;
      else stuck++;
    end
    $display("Timeout: no transfer for %0d cycles, %0d responses outstanding",
             WatchdogLimit, expected_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_n           = 1'b0;
    req_if.valid    = 1'b0;
    req_if.opcode   = '0;
    req_if.value    = '0;
    req_if.position = '0;
    rsp_if.ready    = 1'b0;
    steady_flow     = 1'b0;
    list_len        = 0;
    mismatches      = 0;
    requests_sent   = 0;
    responses_checked = 0;
    foreach (status_hits[s]) status_hits[s] = 0;
    foreach (list_words[w]) list_words[w] = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_basic_ops();
    test_fill_and_drain(5);
    test_random_mix(480);

    // Drop valid, let every owed response arrive, then hold off a little longer
    // so a stray extra response would still be caught.
    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Ran %0d list operations, checked %0d responses, %0d mismatches",
             requests_sent, responses_checked, mismatches);
    $display("Outcomes: %0d ok, %0d empty, %0d bad position, %0d full",
             status_hits[ST_OK], status_hits[ST_EMPTY], status_hits[ST_BADPOS],
             status_hits[ST_FULL]);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pls_pkg.sv
rtl/pls_intf.sv
rtl/pls_ctrl.sv
rtl/pls_dpath.sv
rtl/positional_list_store.sv
rtl/pls_checker.sv
tb/tb_positional_list_store.sv
